### sv/rbpf_pkg.sv
// Shared types and constants for the relay bank pulse/failsafe controller.
// No dependencies; imported by the core, front and back modules of the block.
`timescale 1ns / 1ps

package rbpf_pkg;

    // Fixed field widths
    localparam int RELAY_W   = 8;
    localparam int NOW_W     = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int SRC_W     = 5;
    localparam int STATUS_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MASK      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOMENTARY_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_HIGH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAVE_HOLDOFF   = 3'd5;

    // Change source tags; FAILSAFE and PULSE_END lie beyond the requester range
    localparam logic [SRC_W-1:0] SRC_NONE      = 5'd0;
    localparam logic [SRC_W-1:0] SRC_FAILSAFE  = 5'd16;
    localparam logic [SRC_W-1:0] SRC_PULSE_END = 5'd17;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CH  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WR_FAIL = 2'd2;

    // Item kind, encoded as on the mode port
    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_LINK = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // Classified item passed from front to back
    typedef struct packed {
        op_t                op;
        logic               ch_valid;
        logic [RELAY_W-1:0] ch_bit;
        logic               turn_on;
        logic [3:0]         requester;
        logic [NOW_W-1:0]   now_ms;
        logic               write_ok;
        logic               save_ok;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [RELAY_W-1:0]  relay_state;
        logic [RELAY_W-1:0]  changed_bits;
        logic [SRC_W-1:0]    change_source;
        logic                write_strobe;
        logic [RELAY_W-1:0]  drive_value;
        logic [STATUS_W-1:0] status;
        logic                bus_fault;
        logic                save_strobe;
        logic [RELAY_W-1:0]  save_value;
    } res_t;

endpackage

### sv/relay_bank_pulse_failsafe_ctrl_core.sv
// Top level of the relay bank pulse/failsafe controller.
// Depends on rbpf_pkg, rbpf_front, rbpf_fifo and rbpf_back.
`timescale 1ns / 1ps

//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------------
//  input    | push / full      | mode, channel, turn_on, requester, now_ms,
//           |                  | write_ok, save_ok
//  result   | empty / pop      | relay_state, changed_bits, change_source,
//           |                  | write_strobe, drive_value, status, bus_fault,
//           |                  | save_strobe, save_value
//  config   | wr_en            | wr_index, wr_data
//
// One item per cycle sustained while the result side pops every cycle. An item
// goes from the input into a two-entry command queue, is executed
// combinationally by the back end (eight deadline comparators in parallel) and
// is registered in a two-entry result queue, from which it shows on the result
// ports. Reset is asynchronous and clears state and queues; configuration
// returns to its documented defaults. A stalled result side fills the result
// queue, then the command queue, then raises full.

module relay_bank_pulse_failsafe_ctrl_core
    import rbpf_pkg::*;
#(
    parameter int RELAY_COUNT    = 8,
    parameter int PULSE_LEN_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input items
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           mode,
    input  logic [3:0]           channel,
    input  logic                 turn_on,
    input  logic [3:0]           requester,
    input  logic [NOW_W-1:0]     now_ms,
    input  logic                 write_ok,
    input  logic                 save_ok,
    // result items
    output logic                 empty,
    input  logic                 pop,
    output logic [RELAY_W-1:0]   relay_state,
    output logic [RELAY_W-1:0]   changed_bits,
    output logic [SRC_W-1:0]     change_source,
    output logic                 write_strobe,
    output logic [RELAY_W-1:0]   drive_value,
    output logic [STATUS_W-1:0]  status,
    output logic                 bus_fault,
    output logic                 save_strobe,
    output logic [RELAY_W-1:0]   save_value,
    // configuration
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    localparam int QDEPTH = 2;

    cmd_t cmd_in, cmd_out;
    res_t res_in, res_out;
    logic cmd_empty, cmd_pop;
    logic res_full, res_push;
    logic [$bits(cmd_t)-1:0] cmd_q_data;
    logic [$bits(res_t)-1:0] res_q_data;

    // classify incoming items
    rbpf_front #(
        .RELAY_COUNT (RELAY_COUNT)
    ) u_front (
        .mode      (mode),
        .channel   (channel),
        .turn_on   (turn_on),
        .requester (requester),
        .now_ms    (now_ms),
        .write_ok  (write_ok),
        .save_ok   (save_ok),
        .cmd       (cmd_in)
    );

    // command queue between front and back
    rbpf_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QDEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd_q_data),
        .empty   (cmd_empty)
    );

    assign cmd_out = cmd_t'(cmd_q_data);

    // execute items against relay state
    rbpf_back #(
        .RELAY_COUNT    (RELAY_COUNT),
        .PULSE_LEN_BITS (PULSE_LEN_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue
    rbpf_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QDEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_q_data),
        .empty   (empty)
    );

    assign res_out       = res_t'(res_q_data);
    assign relay_state   = res_out.relay_state;
    assign changed_bits  = res_out.changed_bits;
    assign change_source = res_out.change_source;
    assign write_strobe  = res_out.write_strobe;
    assign drive_value   = res_out.drive_value;
    assign status        = res_out.status;
    assign bus_fault     = res_out.bus_fault;
    assign save_strobe   = res_out.save_strobe;
    assign save_value    = res_out.save_value;

endmodule

### sv/rbpf_fifo.sv
// Small register queue with first-word fall-through read.
// No package dependency; used for the command and result queues.
`timescale 1ns / 1ps

module rbpf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### sv/rbpf_front.sv
// Front end: decodes the item kind and checks/decodes the channel number.
// Depends on rbpf_pkg.
`timescale 1ns / 1ps

module rbpf_front
    import rbpf_pkg::*;
#(
    parameter int RELAY_COUNT = 8
) (
    input  logic [1:0]       mode,
    input  logic [3:0]       channel,
    input  logic             turn_on,
    input  logic [3:0]       requester,
    input  logic [NOW_W-1:0] now_ms,
    input  logic             write_ok,
    input  logic             save_ok,
    output cmd_t             cmd
);

    logic [2:0] ch_idx;

    assign ch_idx = 3'(channel - 4'd1);

    // item kind: op codes match the mode port one to one
    assign cmd.op = op_t'(mode);

    // channel range check and one-hot relay select
    assign cmd.ch_valid  = (channel != 4'd0) && (channel <= 4'(RELAY_COUNT));
    assign cmd.ch_bit    = RELAY_W'(1) << ch_idx;
    assign cmd.turn_on   = turn_on;
    assign cmd.requester = requester;
    assign cmd.now_ms    = now_ms;
    assign cmd.write_ok  = write_ok;
    assign cmd.save_ok   = save_ok;

endmodule

### sv/rbpf_back.sv
// Back end: configuration registers, relay/pulse/save state and item execution.
// Depends on rbpf_pkg.
`timescale 1ns / 1ps

module rbpf_back
    import rbpf_pkg::*;
#(
    parameter int RELAY_COUNT    = 8,
    parameter int PULSE_LEN_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration writes
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    // command queue side
    input  cmd_t                 cmd,
    input  logic                 cmd_empty,
    output logic                 cmd_pop,
    // result queue side
    input  logic                 res_full,
    output logic                 res_push,
    output res_t                 res
);

    localparam logic [RELAY_W-1:0] CH_MASK = RELAY_W'((1 << RELAY_COUNT) - 1);

    // configuration
    logic [RELAY_W-1:0] hold_mask_reg, momentary_mask_reg;
    logic [CFG_W-1:0]   pulse_low_reg, pulse_high_reg;
    logic               drive_high_reg;
    logic [NOW_W-1:0]   holdoff_reg;

    // state
    logic [RELAY_W-1:0] relay_mask_reg, relay_mask_next;
    logic [RELAY_W-1:0] running_reg, running_next;
    logic [NOW_W-1:0]   deadline_reg [RELAY_COUNT];
    logic               save_pending_reg, save_pending_next;
    logic [NOW_W-1:0]   last_save_reg, last_save_next;
    logic               hexp_reg, hexp_next;
    logic               fault_reg, fault_next;

    // datapath
    logic [NOW_W-1:0]   pulse_len [RELAY_COUNT];
    logic [NOW_W-1:0]   lane_age [RELAY_COUNT];
    logic [NOW_W-1:0]   sel_len;
    logic [NOW_W-1:0]   new_deadline;
    logic               start_pulse;
    logic [RELAY_W-1:0] ended;
    logic [RELAY_W-1:0] held;
    logic [RELAY_W-1:0] target;
    logic               commit_req;
    logic               need_write;
    logic               commit_ok;
    logic [NOW_W-1:0]   since_save;

    assign cmd_pop  = !cmd_empty && !res_full;
    assign res_push = cmd_pop;
    assign held     = hold_mask_reg & CH_MASK;

    // per-lane pulse length, expiry and selected length
    always_comb
    begin
        sel_len = '0;
        ended   = '0;
        for (int i = 0; i < RELAY_COUNT; i++)
        begin
            if (i < 4)
            begin
                pulse_len[i] = NOW_W'(pulse_low_reg[16*(i%4) +: PULSE_LEN_BITS]);
            end
            else
            begin
                pulse_len[i] = NOW_W'(pulse_high_reg[16*(i%4) +: PULSE_LEN_BITS]);
            end
            if (cmd.ch_bit[i])
            begin
                sel_len = pulse_len[i];
            end
            // wrap-safe: deadline reached when now - deadline is non-negative
            lane_age[i] = cmd.now_ms - deadline_reg[i];
            ended[i]    = running_reg[i] && !lane_age[i][NOW_W-1];
        end
    end

    assign new_deadline = cmd.now_ms + sel_len;

    // commit target per item kind
    always_comb
    begin
        commit_req = 1'b0;
        target     = relay_mask_reg;
        case (cmd.op)
            OP_SET:
            begin
                commit_req = cmd.ch_valid;
                target     = cmd.turn_on ? (relay_mask_reg | cmd.ch_bit)
                                         : (relay_mask_reg & ~cmd.ch_bit);
            end
            OP_LINK:
            begin
                commit_req = 1'b1;
                target     = relay_mask_reg & held;
            end
            OP_TICK:
            begin
                commit_req = (ended != '0);
                target     = relay_mask_reg & ~ended;
            end
            default:
            begin
                commit_req = 1'b0;
            end
        endcase
    end

    assign need_write = commit_req && (target != relay_mask_reg);
    assign commit_ok  = !need_write || cmd.write_ok;

    // state update and result
    always_comb
    begin
        relay_mask_next   = relay_mask_reg;
        running_next      = running_reg;
        save_pending_next = save_pending_reg;
        last_save_next    = last_save_reg;
        hexp_next         = hexp_reg;
        fault_next        = fault_reg;
        start_pulse       = 1'b0;
        since_save        = '0;

        res.change_source = SRC_NONE;
        res.status        = ST_OK;
        res.write_strobe  = need_write;
        res.drive_value   = '0;
        res.save_strobe   = 1'b0;
        res.save_value    = '0;

        // expander write
        if (need_write)
        begin
            res.drive_value = drive_high_reg ? target : ~target;
            fault_next      = !cmd.write_ok;
            if (cmd.write_ok)
            begin
                relay_mask_next = target;
                if (((target ^ relay_mask_reg) & held) != '0)
                begin
                    save_pending_next = 1'b1;
                end
            end
        end

        case (cmd.op)
            OP_SET:
            begin
                res.change_source = {1'b0, cmd.requester};
                if (!cmd.ch_valid)
                begin
                    res.status = ST_BAD_CH;
                end
                else if (!commit_ok)
                begin
                    res.status = ST_WR_FAIL;
                end
                else if (cmd.turn_on)
                begin
                    if ((momentary_mask_reg & cmd.ch_bit) != '0)
                    begin
                        start_pulse  = 1'b1;
                        running_next = running_reg | cmd.ch_bit;
                    end
                end
                else
                begin
                    running_next = running_reg & ~cmd.ch_bit;
                end
            end
            OP_LINK:
            begin
                res.change_source = SRC_FAILSAFE;
                if (commit_ok)
                begin
                    running_next = running_reg & held;
                end
                else
                begin
                    res.status = ST_WR_FAIL;
                end
            end
            OP_TICK:
            begin
                res.change_source = SRC_PULSE_END;
                if (commit_ok)
                begin
                    running_next = running_reg & ~ended;
                end
                else
                begin
                    res.status = ST_WR_FAIL;
                end
                // deferred save after the pulse ends are applied
                since_save = cmd.now_ms - last_save_reg;
                if (save_pending_next && (hexp_reg || since_save >= holdoff_reg))
                begin
                    res.save_strobe = 1'b1;
                    res.save_value  = relay_mask_next & held;
                    if (cmd.save_ok)
                    begin
                        save_pending_next = 1'b0;
                    end
                    last_save_next = cmd.now_ms;
                    hexp_next      = 1'b0;
                end
            end
            default:
            begin
                res.change_source = SRC_NONE;
            end
        endcase

        res.relay_state  = relay_mask_next;
        res.changed_bits = relay_mask_reg ^ relay_mask_next;
        res.bus_fault    = fault_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_mask_reg      <= '0;
            momentary_mask_reg <= '0;
            pulse_low_reg      <= '0;
            pulse_high_reg     <= '0;
            drive_high_reg     <= 1'b1;
            holdoff_reg        <= NOW_W'(1000);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_HOLD_MASK:      hold_mask_reg      <= wr_data[RELAY_W-1:0];
                REG_MOMENTARY_MASK: momentary_mask_reg <= wr_data[RELAY_W-1:0];
                REG_PULSE_LOW:      pulse_low_reg      <= wr_data;
                REG_PULSE_HIGH:     pulse_high_reg     <= wr_data;
                REG_DRIVE_HIGH:     drive_high_reg     <= wr_data[0];
                REG_SAVE_HOLDOFF:   holdoff_reg        <= wr_data[NOW_W-1:0];
                default:            ;
            endcase
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_mask_reg   <= '0;
            running_reg      <= '0;
            save_pending_reg <= 1'b0;
            last_save_reg    <= '0;
            hexp_reg         <= 1'b1;
            fault_reg        <= 1'b0;
        end
        else if (cmd_pop)
        begin
            relay_mask_reg   <= relay_mask_next;
            running_reg      <= running_next;
            save_pending_reg <= save_pending_next;
            last_save_reg    <= last_save_next;
            hexp_reg         <= hexp_next;
            fault_reg        <= fault_next;
        end
    end

    // pulse deadlines, one lane per relay
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RELAY_COUNT; i++)
            begin
                deadline_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < RELAY_COUNT; i++)
            begin
                if (cmd_pop && start_pulse && cmd.ch_bit[i])
                begin
                    deadline_reg[i] <= new_deadline;
                end
            end
        end
    end

endmodule

### verif/testbench.sv
// Self-checking testbench for relay_bank_pulse_failsafe_ctrl_core.
// Depends on rbpf_pkg and the core RTL; a behavioral relay-bank predictor checks
// every result item, covering directed cases and random phases under random flow control.
`timescale 1ns / 1ps

module testbench;
    import rbpf_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 190;
    localparam int TAIL_CYCLES  = 10;

    // One input item
    typedef struct packed {
        op_t        op;
        logic [3:0] channel;
        logic       turn_on;
        logic [3:0] requester;
        logic [31:0] now_ms;
        logic       write_ok;
        logic       save_ok;
    } relay_item_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // Directed stimulus row: an item (optionally with a typed expectation) or a register write
    typedef struct packed {
        row_kind_t            kind;
        relay_item_t          item;
        logic                 has_exp;
        res_t                 exp_res;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_data;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [1:0]           mode = 2'd0;
    logic [3:0]           channel = 4'd0;
    logic                 turn_on = 1'b0;
    logic [3:0]           requester = 4'd0;
    logic [NOW_W-1:0]     now_ms = '0;
    logic                 write_ok = 1'b0;
    logic                 save_ok = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [RELAY_W-1:0]   relay_state;
    logic [RELAY_W-1:0]   changed_bits;
    logic [SRC_W-1:0]     change_source;
    logic                 write_strobe;
    logic [RELAY_W-1:0]   drive_value;
    logic [STATUS_W-1:0]  status;
    logic                 bus_fault;
    logic                 save_strobe;
    logic [RELAY_W-1:0]   save_value;
    logic                 wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] wr_index = '0;
    logic [CFG_W-1:0]     wr_data = '0;

    // Predictor copy of the configuration
    logic [7:0]  hold_cfg;
    logic [7:0]  momentary_cfg;
    logic [63:0] pulse_lo_cfg;
    logic [63:0] pulse_hi_cfg;
    logic        active_high_cfg;
    logic [31:0] holdoff_cfg;

    // Predictor copy of the state
    logic [7:0]  relays_on;
    logic [7:0]  pulses_live;
    logic [31:0] pulse_due [8];
    logic        save_owed;
    logic        save_first;
    logic [31:0] prev_save_at;
    logic        fault_seen;
    logic        wr_flag;
    logic [7:0]  wr_word;

    res_t        relay_results_due [$];
    stim_row_t   directed_rows [$];
    logic [31:0] ms_clock;
    int          mismatches = 0;
    int          results_checked = 0;
    int          cycle_count = 0;

    relay_bank_pulse_failsafe_ctrl_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .channel       (channel),
        .turn_on       (turn_on),
        .requester     (requester),
        .now_ms        (now_ms),
        .write_ok      (write_ok),
        .save_ok       (save_ok),
        .empty         (empty),
        .pop           (pop),
        .relay_state   (relay_state),
        .changed_bits  (changed_bits),
        .change_source (change_source),
        .write_strobe  (write_strobe),
        .drive_value   (drive_value),
        .status        (status),
        .bus_fault     (bus_fault),
        .save_strobe   (save_strobe),
        .save_value    (save_value),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data)
    );

    always #4 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic reset_model();
        hold_cfg        = 8'h00;
        momentary_cfg   = 8'h00;
        pulse_lo_cfg    = '0;
        pulse_hi_cfg    = '0;
        active_high_cfg = 1'b1;
        holdoff_cfg     = 32'd1000;
        relays_on       = 8'h00;
        pulses_live     = 8'h00;
        for (int i = 0; i < 8; i++)
            pulse_due[i] = '0;
        save_owed    = 1'b0;
        save_first   = 1'b1;
        prev_save_at = '0;
        fault_seen   = 1'b0;
    endtask

    function automatic logic [15:0] pulse_length(input int idx);
        if (idx < 4)
            return pulse_lo_cfg[16*idx +: 16];
        return pulse_hi_cfg[16*(idx-4) +: 16];
    endfunction

    // Expander write of a new mask; the mask moves only when the write succeeds
    function automatic logic try_write(input logic [7:0] target, input logic ok);
        if (target == relays_on)
            return 1'b1;
        wr_flag = 1'b1;
        wr_word = active_high_cfg ? target : ~target;
        if (!ok)
        begin
            fault_seen = 1'b1;
            return 1'b0;
        end
        fault_seen = 1'b0;
        if (((target ^ relays_on) & hold_cfg) != 8'h00)
            save_owed = 1'b1;
        relays_on = target;
        return 1'b1;
    endfunction

    function automatic res_t predict_relays(input relay_item_t it);
        res_t        r;
        logic [7:0]  before_mask;
        logic [7:0]  ch_bit;
        logic [7:0]  target;
        logic [7:0]  ended;
        logic [31:0] age;
        int          idx;
        r = '0;
        before_mask = relays_on;
        wr_flag = 1'b0;
        wr_word = 8'h00;
        case (it.op)
            OP_SET:
            begin
                r.change_source = {1'b0, it.requester};
                if (it.channel == 4'd0 || it.channel > 4'd8)
                    r.status = ST_BAD_CH;
                else
                begin
                    idx = int'(it.channel) - 1;
                    ch_bit = 8'd1 << idx;
                    target = it.turn_on ? (relays_on | ch_bit) : (relays_on & ~ch_bit);
                    if (!try_write(target, it.write_ok))
                        r.status = ST_WR_FAIL;
                    else if (it.turn_on && momentary_cfg[idx])
                    begin
                        // (re)start the pulse
                        pulse_due[idx] = it.now_ms + {16'h0000, pulse_length(idx)};
                        pulses_live = pulses_live | ch_bit;
                    end
                    else if (!it.turn_on)
                        pulses_live = pulses_live & ~ch_bit;
                end
            end
            OP_LINK:
            begin
                r.change_source = SRC_FAILSAFE;
                if (try_write(relays_on & hold_cfg, it.write_ok))
                    pulses_live = pulses_live & hold_cfg;
                else
                    r.status = ST_WR_FAIL;
            end
            OP_TICK:
            begin
                r.change_source = SRC_PULSE_END;
                ended = 8'h00;
                // wrap-safe deadline check
                for (int i = 0; i < 8; i++)
                begin
                    age = it.now_ms - pulse_due[i];
                    if (pulses_live[i] && !age[31])
                        ended[i] = 1'b1;
                end
                if (ended != 8'h00)
                begin
                    if (try_write(relays_on & ~ended, it.write_ok))
                        pulses_live = pulses_live & ~ended;
                    else
                        r.status = ST_WR_FAIL;
                end
                // deferred save, holdoff counted from the last attempt
                age = it.now_ms - prev_save_at;
                if (save_owed && (save_first || age >= holdoff_cfg))
                begin
                    r.save_strobe = 1'b1;
                    r.save_value  = relays_on & hold_cfg;
                    if (it.save_ok)
                        save_owed = 1'b0;
                    prev_save_at = it.now_ms;
                    save_first   = 1'b0;
                end
            end
            default: ;
        endcase
        r.relay_state  = relays_on;
        r.changed_bits = before_mask ^ relays_on;
        r.write_strobe = wr_flag;
        r.drive_value  = wr_word;
        r.bus_fault    = fault_seen;
        return r;
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] short_pulses();
        logic [63:0] v;
        for (int k = 0; k < 4; k++)
            v[16*k +: 16] = 16'($urandom_range(0, 400));
        return v;
    endfunction

    function automatic relay_item_t random_item();
        relay_item_t it;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 50)
            it.op = OP_SET;
        else if (r < 57)
            it.op = OP_LINK;
        else if (r < 97)
            it.op = OP_TICK;
        else
            it.op = OP_NONE;
        if ($urandom_range(0, 99) < 88)
            it.channel = 4'($urandom_range(1, 8));
        else
            it.channel = 4'($urandom_range(0, 15));
        it.turn_on   = 1'($urandom_range(0, 1));
        it.requester = 4'($urandom_range(0, 15));
        // millisecond clock: small steps, now and then a jump
        if ($urandom_range(0, 99) < 3)
            ms_clock = $urandom;
        else
            ms_clock = ms_clock + $urandom_range(0, 60);
        it.now_ms   = ms_clock;
        it.write_ok = ($urandom_range(0, 99) < 90);
        it.save_ok  = ($urandom_range(0, 99) < 80);
        return it;
    endfunction

    task automatic add_item(input op_t op, input logic [3:0] ch, input logic on,
                            input logic [3:0] req, input logic [31:0] now,
                            input logic wok, input logic sok,
                            input logic has, input res_t res);
        stim_row_t row;
        row = '0;
        row.kind           = ROW_ITEM;
        row.item.op        = op;
        row.item.channel   = ch;
        row.item.turn_on   = on;
        row.item.requester = req;
        row.item.now_ms    = now;
        row.item.write_ok  = wok;
        row.item.save_ok   = sok;
        row.has_exp        = has;
        row.exp_res        = res;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.kind     = ROW_CFG;
        row.reg_idx  = idx;
        row.reg_data = data;
        directed_rows.push_back(row);
    endtask

    // Leaves wr_en high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            REG_HOLD_MASK:      hold_cfg        = data[7:0];
            REG_MOMENTARY_MASK: momentary_cfg   = data[7:0];
            REG_PULSE_LOW:      pulse_lo_cfg    = data;
            REG_PULSE_HIGH:     pulse_hi_cfg    = data;
            REG_DRIVE_HIGH:     active_high_cfg = data[0];
            REG_SAVE_HOLDOFF:   holdoff_cfg     = data[31:0];
            default: ;
        endcase
    endtask

    // Wait until every expected item is back and the block is quiet
    task automatic settle();
        push <= 1'b0;
        while (relay_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_item(input relay_item_t it, input logic has_exp, input res_t typed);
        res_t model_res;
        int   gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        mode      <= it.op;
        channel   <= it.channel;
        turn_on   <= it.turn_on;
        requester <= it.requester;
        now_ms    <= it.now_ms;
        write_ok  <= it.write_ok;
        save_ok   <= it.save_ok;
        @(posedge clk);
        while (full)
            @(posedge clk);
        model_res = predict_relays(it);
        relay_results_due.push_back(has_exp ? typed : model_res);
    endtask

    task automatic apply_phase(input int p);
        case (p)
            0:
            begin
                write_reg(REG_HOLD_MASK, 64'hFF);
                write_reg(REG_MOMENTARY_MASK, 64'h0F);
                write_reg(REG_PULSE_LOW, short_pulses());
                write_reg(REG_PULSE_HIGH, short_pulses());
                write_reg(REG_DRIVE_HIGH, 64'd1);
                write_reg(REG_SAVE_HOLDOFF, 64'd0);
            end
            1:
            begin
                write_reg(REG_HOLD_MASK, 64'h00);
                write_reg(REG_MOMENTARY_MASK, 64'hFF);
                write_reg(REG_PULSE_LOW, {64{1'b1}});
                write_reg(REG_PULSE_HIGH, {64{1'b1}});
                write_reg(REG_DRIVE_HIGH, 64'd0);
                write_reg(REG_SAVE_HOLDOFF, 64'hFFFF_FFFF);
            end
            3:
            begin
                write_reg(REG_HOLD_MASK, 64'($urandom_range(0, 255)));
                write_reg(REG_MOMENTARY_MASK, 64'($urandom_range(0, 255)));
                write_reg(REG_PULSE_LOW, {$urandom, $urandom});
                write_reg(REG_PULSE_HIGH, {$urandom, $urandom});
                write_reg(REG_DRIVE_HIGH, 64'($urandom_range(0, 1)));
                write_reg(REG_SAVE_HOLDOFF, 64'd50);
            end
            default:
            begin
                write_reg(REG_HOLD_MASK, 64'($urandom_range(0, 255)));
                write_reg(REG_MOMENTARY_MASK, 64'($urandom_range(0, 255)));
                write_reg(REG_PULSE_LOW, short_pulses());
                write_reg(REG_PULSE_HIGH, short_pulses());
                write_reg(REG_DRIVE_HIGH, 64'($urandom_range(0, 1)));
                write_reg(REG_SAVE_HOLDOFF, 64'($urandom_range(0, 2000)));
            end
        endcase
        wr_en <= 1'b0;
        // clock start: near the wrap in one phase, anywhere otherwise
        ms_clock = (p == 2) ? 32'hFFFF_F800 : $urandom;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        res_t want;
        if (relay_results_due.size() == 0)
        begin
            $error("result item with no expectation waiting: relay_state %0h", relay_state);
            mismatches++;
        end
        else
        begin
            want = relay_results_due.pop_front();
            compare_field("relay_state", want.relay_state, relay_state);
            compare_field("changed_bits", want.changed_bits, changed_bits);
            compare_field("change_source", 8'(want.change_source), 8'(change_source));
            compare_field("write_strobe", 8'(want.write_strobe), 8'(write_strobe));
            compare_field("drive_value", want.drive_value, drive_value);
            compare_field("status", 8'(want.status), 8'(status));
            compare_field("bus_fault", 8'(want.bus_fault), 8'(bus_fault));
            compare_field("save_strobe", 8'(want.save_strobe), 8'(save_strobe));
            compare_field("save_value", want.save_value, save_value);
        end
        results_checked++;
    endtask

    // Directed rows; typed results are {relay_state, changed_bits, change_source,
    // write_strobe, drive_value, status, bus_fault, save_strobe, save_value}
    task automatic build_directed();
        // defaults: nothing held, nothing momentary, active-high drive
        add_item(OP_SET, 4'd0, 1'b1, 4'd3, 32'd0, 1'b1, 1'b1, 1'b1,
                 {8'h00, 8'h00, 5'd3, 1'b0, 8'h00, ST_BAD_CH, 1'b0, 1'b0, 8'h00});
        add_item(OP_SET, 4'd9, 1'b1, 4'd15, 32'd0, 1'b1, 1'b1, 1'b1,
                 {8'h00, 8'h00, 5'd15, 1'b0, 8'h00, ST_BAD_CH, 1'b0, 1'b0, 8'h00});
        add_item(OP_SET, 4'd15, 1'b0, 4'd0, 32'd0, 1'b1, 1'b1, 1'b1,
                 {8'h00, 8'h00, 5'd0, 1'b0, 8'h00, ST_BAD_CH, 1'b0, 1'b0, 8'h00});
        add_item(OP_SET, 4'd1, 1'b1, 4'd1, 32'd1, 1'b1, 1'b1, 1'b1,
                 {8'h01, 8'h01, 5'd1, 1'b1, 8'h01, ST_OK, 1'b0, 1'b0, 8'h00});
        // failed write, then the retry that clears the fault
        add_item(OP_SET, 4'd8, 1'b1, 4'd2, 32'd2, 1'b0, 1'b1, 1'b1,
                 {8'h01, 8'h00, 5'd2, 1'b1, 8'h81, ST_WR_FAIL, 1'b1, 1'b0, 8'h00});
        add_item(OP_SET, 4'd8, 1'b1, 4'd2, 32'd3, 1'b1, 1'b1, 1'b1,
                 {8'h81, 8'h80, 5'd2, 1'b1, 8'h81, ST_OK, 1'b0, 1'b0, 8'h00});
        // unchanged target: no write, write_ok ignored
        add_item(OP_SET, 4'd1, 1'b1, 4'd4, 32'd4, 1'b0, 1'b1, 1'b1,
                 {8'h81, 8'h00, 5'd4, 1'b0, 8'h00, ST_OK, 1'b0, 1'b0, 8'h00});
        add_item(OP_NONE, 4'd5, 1'b1, 4'd9, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
                 {8'h81, 8'h00, SRC_NONE, 1'b0, 8'h00, ST_OK, 1'b0, 1'b0, 8'h00});
        add_item(OP_LINK, 4'd0, 1'b0, 4'd0, 32'd5, 1'b1, 1'b1, 1'b1,
                 {8'h00, 8'h81, SRC_FAILSAFE, 1'b1, 8'h00, ST_OK, 1'b0, 1'b0, 8'h00});
        add_item(OP_TICK, 4'd0, 1'b0, 4'd0, 32'd6, 1'b1, 1'b1, 1'b1,
                 {8'h00, 8'h00, SRC_PULSE_END, 1'b0, 8'h00, ST_OK, 1'b0, 1'b0, 8'h00});
        // relays 1-4 held, 5-8 momentary with pulses 0, 0xFFFF, 10 and 5 ms
        add_cfg(REG_HOLD_MASK, 64'h0F);
        add_cfg(REG_MOMENTARY_MASK, 64'hF0);
        add_cfg(REG_PULSE_LOW, {64{1'b1}});
        add_cfg(REG_PULSE_HIGH, 64'h0005_000A_FFFF_0000);
        add_cfg(REG_DRIVE_HIGH, 64'd0);
        add_cfg(REG_SAVE_HOLDOFF, 64'd100);
        add_item(OP_SET, 4'd5, 1'b1, 4'd6, 32'd1000, 1'b1, 1'b1, 1'b0, '0);
        add_item(OP_SET, 4'd2, 1'b1, 4'd7, 32'd1000, 1'b1, 1'b1, 1'b0, '0);
        // zero-length pulse ends; first save goes out at once but fails
        add_item(OP_TICK, 4'd0, 1'b0, 4'd0, 32'd1000, 1'b1, 1'b0, 1'b0, '0);
        add_item(OP_TICK, 4'd0, 1'b0, 4'd0, 32'd1050, 1'b1, 1'b1, 1'b0, '0);
        add_item(OP_TICK, 4'd0, 1'b0, 4'd0, 32'd1100, 1'b1, 1'b1, 1'b0, '0);
        // deadline wraps past zero and must not end early
        add_item(OP_SET, 4'd6, 1'b1, 4'd8, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0, '0);
        add_item(OP_TICK, 4'd0, 1'b0, 4'd0, 32'h0000_0010, 1'b1, 1'b1, 1'b0, '0);
        // pulse restart on a running momentary relay
        add_item(OP_SET, 4'd7, 1'b1, 4'd10, 32'h7FFF_0000, 1'b1, 1'b1, 1'b0, '0);
        add_item(OP_SET, 4'd7, 1'b1, 4'd11, 32'h7FFF_0100, 1'b1, 1'b1, 1'b0, '0);
        add_item(OP_TICK, 4'd0, 1'b0, 4'd0, 32'h7FFF_0109, 1'b1, 1'b1, 1'b0, '0);
        add_item(OP_TICK, 4'd0, 1'b0, 4'd0, 32'h7FFF_010A, 1'b0, 1'b1, 1'b0, '0);
        add_item(OP_TICK, 4'd0, 1'b0, 4'd0, 32'h7FFF_010A, 1'b1, 1'b1, 1'b0, '0);
        // link loss with a failing write, then a good one
        add_item(OP_SET, 4'd8, 1'b1, 4'd12, 32'h7FFF_0200, 1'b1, 1'b1, 1'b0, '0);
        add_item(OP_LINK, 4'd3, 1'b1, 4'd0, 32'h7FFF_0201, 1'b0, 1'b1, 1'b0, '0);
        add_item(OP_LINK, 4'd3, 1'b1, 4'd0, 32'h7FFF_0202, 1'b1, 1'b1, 1'b0, '0);
        add_item(OP_SET, 4'd2, 1'b0, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, '0);
    endtask

    // Receiver: random pop gaps plus a couple of long hold-offs
    initial
    begin
        int idle_left;
        int next_hold_at;
        idle_left = 0;
        next_hold_at = 300;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                check_result();
                if (results_checked == next_hold_at)
                begin
                    idle_left = 150;
                    next_hold_at += 450;
                end
            end
            if (idle_left > 0)
            begin
                pop <= 1'b0;
                idle_left--;
            end
            else
            begin
                pop <= 1'b1;
                idle_left = pick_gap();
            end
        end
    end

    // Sender and run control
    initial
    begin
        stim_row_t row;
        logic      cfg_open;
        reset_model();
        cfg_open = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        build_directed();
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
            begin
                if (!cfg_open)
                begin
                    settle();
                    cfg_open = 1'b1;
                end
                write_reg(row.reg_idx, row.reg_data);
            end
            else
            begin
                if (cfg_open)
                begin
                    wr_en <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_item(row.item, row.has_exp, row.exp_res);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            settle();
            apply_phase(p);
            repeat (PHASE_ITEMS)
                send_item(random_item(), 1'b0, '0);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
sv/rbpf_pkg.sv
sv/rbpf_fifo.sv
sv/rbpf_front.sv
sv/rbpf_back.sv
sv/relay_bank_pulse_failsafe_ctrl_core.sv
verif/testbench.sv
